### hdl/fcfl_pkg.sv
// Shared constants and types for the fixed chunk free list allocator.
package fcfl_pkg;

   // Pool geometry
   localparam int MAX_CHUNKS = 1024;
   localparam int IDX_W      = 10;
   localparam int LINK_W     = IDX_W + 1;
   localparam int COUNT_W    = 11;
   localparam int BYTES_W    = 17;
   localparam int OFFSET_W   = 26;
   localparam int PROD_W     = IDX_W + BYTES_W;
   localparam int STATUS_W   = 2;

   // Register file
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [LINK_W-1:0]   link_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [BYTES_W-1:0]  bytes_type;
   typedef logic [OFFSET_W-1:0] offset_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Null link: top bit set, index bits zero
   localparam link_type LINK_NULL = {1'b1, {IDX_W{1'b0}}};

   // Reset values
   localparam count_type COUNT_RESET = count_type'(MAX_CHUNKS);
   localparam bytes_type BYTES_RESET = bytes_type'(64);

   // Register indexes
   localparam logic REG_CHUNK_COUNT = 1'b0;
   localparam logic REG_CHUNK_BYTES = 1'b1;

   // Request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Response status codes
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_RANGE = 2'd2;

   // Clip a written count into 1..MAX_CHUNKS
   function automatic count_type clip_count(input count_type value);
      count_type result;
      if (value == '0) begin
         result = count_type'(1);
      end else if (value > count_type'(MAX_CHUNKS)) begin
         result = count_type'(MAX_CHUNKS);
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

### hdl/fcfl_req_if.sv
// Request channel interface: allocate or free transactions.
interface fcfl_req_if;
   import fcfl_pkg::*;

   logic    valid;
   logic    ready;
   logic    action;
   idx_type chunk_index;

   modport source (output valid, output action, output chunk_index, input ready);
   modport sink   (input valid, input action, input chunk_index, output ready);
endinterface

### hdl/fcfl_rsp_if.sv
// Response channel interface: status, granted chunk and byte offset.
interface fcfl_rsp_if;
   import fcfl_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   idx_type    granted_index;
   offset_type byte_offset;

   modport source (output valid, output status, output granted_index, output byte_offset,
                   input ready);
   modport sink   (input valid, input status, input granted_index, input byte_offset,
                   output ready);
endinterface

### hdl/fixed_chunk_free_list_allocator.sv
// Fixed chunk pool allocator: LIFO free list held in a link memory.
//
// Usage:
//   req_bus carries one transaction per item: action 0 pops a chunk from the
//   free list, action 1 pushes chunk_index back. rsp_bus returns one
//   transaction per request, in order: status, granted_index, byte_offset.
//   The csr_ port holds chunk_count (address 0) and chunk_bytes (address 4).
//   Writing chunk_count rebuilds the free list in ascending order.
// Timing:
//   An accepted alloc reads the link memory through its registered read port;
//   every request then commits from the EXEC state once the output register
//   is free, and no new request is accepted until it has committed. The
//   response is valid the cycle after commit.
// Reset and stalls:
//   After reset, and after each chunk_count write, a fill pass writes all
//   1024 links, one per cycle; req_bus.ready stays low until the pass ends.
//   The response sits in an output register, so one new request is accepted
//   while a response waits; a second one holds until rsp_bus.ready.
module fixed_chunk_free_list_allocator (
   input  logic                     clock,
   input  logic                     reset,
   fcfl_req_if.sink                 req_bus,
   fcfl_rsp_if.source               rsp_bus,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [fcfl_pkg::PADDR_W-1:0] csr_paddr,
   input  logic [fcfl_pkg::PDATA_W-1:0] csr_pwdata,
   output logic [fcfl_pkg::PDATA_W-1:0] csr_prdata,
   output logic                     csr_pready
);
   import fcfl_pkg::*;

   localparam logic [1:0] ST_FILL = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   // Control state
   logic [1:0] state_ff, state_in;
   idx_type    fill_ff, fill_in;
   link_type   head_ff, head_in;
   count_type  count_ff, count_in;
   bytes_type  bytes_ff, bytes_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Latched request
   logic       action_ff;
   idx_type    index_ff;

   // Output payload
   status_type status_ff, status_in;
   idx_type    grant_ff, grant_in;
   offset_type offset_ff, offset_in;

   // Link memory
   link_type   link_mem [MAX_CHUNKS];
   link_type   rd_data_ff;
   logic       rd_en;
   logic       wr_en;
   idx_type    wr_addr;
   link_type   wr_data;

   logic       req_fire;
   logic       cfg_write;
   logic       commit;
   logic       out_free;
   logic [PROD_W-1:0] product;
   logic [COUNT_W-1:0] fill_next;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign commit    = (state_ff == ST_EXEC) && out_free;
   assign fill_next = COUNT_W'(fill_ff) + COUNT_W'(1);
   assign product   = PROD_W'(head_ff[IDX_W-1:0]) * PROD_W'(bytes_ff);

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rd_en         = req_fire && (req_bus.action == ACT_ALLOC);

   // Register port
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[2])
         REG_CHUNK_COUNT: csr_prdata = PDATA_W'(count_ff);
         REG_CHUNK_BYTES: csr_prdata = PDATA_W'(bytes_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      bytes_in     = bytes_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      grant_in     = grant_ff;
      offset_in    = offset_ff;
      wr_en        = 1'b0;
      wr_addr      = index_ff;
      wr_data      = head_ff;

      case (state_ff)
         ST_FILL: begin
            // Link each entry to its successor, null past the last chunk
            wr_en   = 1'b1;
            wr_addr = fill_ff;
            wr_data = (fill_next < count_ff) ? LINK_W'(fill_next) : LINK_NULL;
            fill_in = fill_ff + idx_type'(1);
            if (fill_ff == idx_type'(MAX_CHUNKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               grant_in     = '0;
               offset_in    = '0;
               if (action_ff == ACT_ALLOC) begin
                  if (head_ff[LINK_W-1]) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     grant_in  = head_ff[IDX_W-1:0];
                     offset_in = product[OFFSET_W-1:0];
                     head_in   = rd_data_ff;
                  end
               end else begin
                  if (COUNT_W'(index_ff) >= count_ff) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     // Push: freed chunk links to the old head
                     wr_en   = 1'b1;
                     wr_addr = index_ff;
                     wr_data = head_ff;
                     head_in = LINK_W'(index_ff);
                  end
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase

      // Configuration writes; a count write restarts the fill pass
      if (cfg_write) begin
         case (csr_paddr[2])
            REG_CHUNK_COUNT: begin
               count_in = clip_count(csr_pwdata[COUNT_W-1:0]);
               state_in = ST_FILL;
               fill_in  = '0;
               head_in  = '0;
            end
            REG_CHUNK_BYTES: begin
               bytes_in = csr_pwdata[BYTES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= clip_count(COUNT_RESET);
         bytes_ff     <= BYTES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff <= req_bus.action;
         index_ff  <= req_bus.chunk_index;
      end
      status_ff <= status_in;
      grant_ff  <= grant_in;
      offset_ff <= offset_in;
   end

   // Link memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= link_mem[head_ff[IDX_W-1:0]];
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.granted_index = grant_ff;
   assign rsp_bus.byte_offset   = offset_ff;

endmodule

### dv/tb_top.sv
// Testbench for the fixed chunk free list allocator: directed and random pool traffic.
`timescale 1ns / 100ps

module tb_top;
   import fcfl_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_TAIL  = 16;

   // CSR byte addresses, one 32-bit word per register
   localparam logic [PADDR_W-1:0] ADDR_CHUNK_COUNT = {REG_CHUNK_COUNT, 2'b00};
   localparam logic [PADDR_W-1:0] ADDR_CHUNK_BYTES = {REG_CHUNK_BYTES, 2'b00};

   typedef struct packed {
      status_type status;
      idx_type    grant;
      offset_type offset;
   } alloc_result_type;

   logic                clock;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [PADDR_W-1:0]  csr_paddr;
   logic [PDATA_W-1:0]  csr_pwdata;
   logic [PDATA_W-1:0]  csr_prdata;
   logic                csr_pready;

   fcfl_req_if req_bus ();
   fcfl_rsp_if rsp_bus ();

   fixed_chunk_free_list_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Pool shadow state
   link_type  pool_head;
   link_type  pool_links [MAX_CHUNKS];
   count_type pool_count;
   bytes_type pool_bytes;

   alloc_result_type pending_results[$];
   int               error_count   = 0;
   int               cycle_count   = 0;
   int               send_idle_pct = 13;
   int               recv_idle_pct = 52;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response backpressure
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Relink every chunk in ascending order
   function automatic void rebuild_pool();
      for (int i = 0; i < MAX_CHUNKS; i++) begin
         pool_links[i] = (i + 1 < int'(pool_count)) ? link_type'(i + 1) : LINK_NULL;
      end
      pool_head = '0;
   endfunction

   function automatic void update_pool_register(input logic reg_sel, input logic [PDATA_W-1:0] value);
      count_type raw_count;
      if (reg_sel == REG_CHUNK_COUNT) begin
         raw_count = value[COUNT_W-1:0];
         if (raw_count == '0) begin
            pool_count = count_type'(1);
         end else if (int'(raw_count) > MAX_CHUNKS) begin
            pool_count = count_type'(MAX_CHUNKS);
         end else begin
            pool_count = raw_count;
         end
         rebuild_pool();
      end else begin
         pool_bytes = value[BYTES_W-1:0];
      end
   endfunction

   // Pop or push on the shadow list, return the response the block owes
   function automatic alloc_result_type predict_pool_op(input logic act, input idx_type idx);
      alloc_result_type   res;
      logic [PROD_W-1:0]  product;
      res = '0;
      if (act == ACT_ALLOC) begin
         if (pool_head[IDX_W]) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.status = STATUS_OK;
            res.grant  = pool_head[IDX_W-1:0];
            product    = PROD_W'(res.grant) * PROD_W'(pool_bytes);
            res.offset = product[OFFSET_W-1:0];
            pool_head  = pool_links[res.grant];
         end
      end else if (COUNT_W'(idx) >= pool_count) begin
         res.status = STATUS_RANGE;
      end else begin
         res.status      = STATUS_OK;
         pool_links[idx] = pool_head;
         pool_head       = {1'b0, idx};
      end
      return res;
   endfunction

   // Response checker
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response with nothing outstanding, status %0d",
                                      rsp_bus.status));
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_bus.status, want.status));
            if (rsp_bus.granted_index !== want.grant)
               report_mismatch($sformatf("granted_index %0d, expected %0d",
                                         rsp_bus.granted_index, want.grant));
            if (rsp_bus.byte_offset !== want.offset)
               report_mismatch($sformatf("byte_offset %0d, expected %0d",
                                         rsp_bus.byte_offset, want.offset));
         end
      end
   end

   // One request transaction, with a random gap ahead of it
   task automatic send_request(input logic act, input idx_type idx);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.action      = act;
      req_bus.chunk_index = idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(predict_pool_op(act, idx));
   endtask

   // Stop sending and wait for every outstanding response
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic reg_sel, input logic [PDATA_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = (reg_sel == REG_CHUNK_COUNT) ? ADDR_CHUNK_COUNT : ADDR_CHUNK_BYTES;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      update_pool_register(reg_sel, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Reset list order, alloc ignores chunk_index, free of a never-allocated chunk
   task automatic test_reset_state();
      send_request(ACT_ALLOC, idx_type'(1023));
      send_request(ACT_ALLOC, idx_type'(0));
      send_request(ACT_FREE,  idx_type'(1));
      send_request(ACT_ALLOC, idx_type'(0));
      send_request(ACT_FREE,  idx_type'(1023));
      send_request(ACT_ALLOC, idx_type'(0));
   endtask

   // Count of zero clips to one chunk: empty pool and out-of-range frees
   task automatic test_single_chunk();
      write_register(REG_CHUNK_COUNT, 32'd0);
      send_request(ACT_ALLOC, idx_type'(0));
      send_request(ACT_ALLOC, idx_type'(0));
      send_request(ACT_FREE,  idx_type'(1));
      send_request(ACT_FREE,  idx_type'(1023));
      send_request(ACT_FREE,  idx_type'(0));
      send_request(ACT_ALLOC, idx_type'(0));
   endtask

   // Oversized count clips to the maximum, offset wraps, double free loops the list
   task automatic test_count_clip_and_overflow();
      write_register(REG_CHUNK_COUNT, 32'd2047);
      write_register(REG_CHUNK_BYTES, 32'd131071);
      send_request(ACT_FREE,  idx_type'(1023));
      send_request(ACT_ALLOC, idx_type'(0));
      send_request(ACT_ALLOC, idx_type'(0));
      send_request(ACT_FREE,  idx_type'(0));
      send_request(ACT_FREE,  idx_type'(0));
      send_request(ACT_ALLOC, idx_type'(0));
      send_request(ACT_ALLOC, idx_type'(0));
   endtask

   // Zero chunk size gives zero offsets; size write leaves the list alone
   task automatic test_zero_and_top_size();
      write_register(REG_CHUNK_BYTES, 32'd0);
      send_request(ACT_ALLOC, idx_type'(0));
      write_register(REG_CHUNK_BYTES, 32'd65536);
      write_register(REG_CHUNK_COUNT, 32'd1024);
      send_request(ACT_ALLOC, idx_type'(0));
      send_request(ACT_ALLOC, idx_type'(0));
   endtask

   // Mostly well-formed alloc/free of held chunks, with stray and bad frees
   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
      idx_type held[$];
      int      pick;
      int      r;
      idx_type idx;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int phase = 0; phase < 2; phase++) begin
         held.delete();
         if (phase == 0) begin
            write_register(REG_CHUNK_COUNT, $urandom_range(1, 24));
         end else begin
            write_register(REG_CHUNK_COUNT, $urandom_range(1000, 2047));
         end
         write_register(REG_CHUNK_BYTES, $urandom_range(0, 131071));
         for (int i = 0; i < n_items; i++) begin
            // hold off once per phase until the pool has answered everything
            if (i == n_items / 2) wait_drained();
            r = $urandom_range(0, 99);
            if (held.size() > 0 && r < 45) begin
               pick = $urandom_range(0, held.size() - 1);
               idx  = held[pick];
               held.delete(pick);
               send_request(ACT_FREE, idx);
            end else if (r < 88) begin
               send_request(ACT_ALLOC, idx_type'($urandom));
               if (pending_results[$].status == STATUS_OK)
                  held.push_back(pending_results[$].grant);
            end else if (r < 94 || int'(pool_count) >= MAX_CHUNKS) begin
               send_request(ACT_FREE, idx_type'($urandom));
            end else begin
               send_request(ACT_FREE, idx_type'($urandom_range(int'(pool_count), 1023)));
            end
         end
      end
   endtask

   // Sequence
   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACT_ALLOC;
      req_bus.chunk_index = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      pool_count          = COUNT_RESET;
      pool_bytes          = BYTES_RESET;
      rebuild_pool();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_single_chunk();
      test_count_clip_and_overflow();
      test_zero_and_top_size();
      test_random_traffic(13, 52, 235);
      test_random_traffic(52, 13, 235);
      test_random_traffic(0, 0, 235);

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
